// ===== design/ttm_pkg.sv =====
// ---------------------------------------------------------------------------
// Timer table manager package
// Shared constants and command codes.
// ---------------------------------------------------------------------------
`default_nettype none
package ttm_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int CMD_W = 3;
    localparam int SID_W = 4;
    localparam int PER_W = 32;
    localparam int OUT_TIME_W = 48;
    localparam logic [31:0] ROLL_RESET = 32'd3600000;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_CANCEL  = 3'd1,
        CMD_REFRESH = 3'd2,
        CMD_RESET   = 3'd3,
        CMD_QUERY   = 3'd4,
        CMD_EXPIRE  = 3'd5
    } cmd_t;

endpackage : ttm_pkg
`default_nettype wire

// ===== design/ttm_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module ttm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule : ttm_ram
`default_nettype wire

// ===== design/timer_table_manager.sv =====
// Flow: a command is latched, then its slot is read and decoded. An add or reset
//   that changes the table, a query and an expire with active timers then scan
//   every slot; an expire that fires scans once more for each fired slot before
//   its result.
// Throughput: one item at a time; in_ready is high only while idle.
// Reset: asynchronous, clears active marks, front flag and previous time.
`default_nettype none
module timer_table_manager
    import ttm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic [SID_W-1:0]      slot_id,
    input  wire logic [PER_W-1:0]      period_ms,
    input  wire logic                  recurring,
    input  wire logic                  restart_now,
    input  wire logic [OUT_TIME_W-1:0] now_ms,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       ok,
    output logic [SID_W-1:0]           timer_id,
    output logic [OUT_TIME_W-1:0]      wait_ms,
    output logic                       is_earliest,
    output logic                       fired,
    output logic                       any_active,
    output logic                       last
);
    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int TW = TIME_BITS;
    localparam logic [TW-1:0] TMAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_SCAN, S_DONE, S_UPD, S_WB, S_NEXT, S_OUT
    } state_t;

    state_t state_reg;
    logic [NUM_SLOTS-1:0] act_reg, rec_reg, due_reg;
    logic [TW-1:0] prev_reg, now_reg;
    logic front_reg;
    logic [31:0] roll_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [SID_W-1:0] sid_reg;
    logic [PER_W-1:0] per_reg;
    logic recin_reg, fnow_reg, roll_hit_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] target_reg;
    logic [IW-1:0] best_reg;
    logic best_ok_reg;
    logic [TW-1:0] best_dl_reg;
    logic [TW-1:0] tdl_reg;
    logic [PER_W-1:0] tper_reg;
    logic o_ok, o_front, o_fired, o_last;
    logic [SID_W-1:0] o_id;
    logic [OUT_TIME_W-1:0] o_wait;

    // Period and deadline memories.
    logic p_we, d_we;
    logic [IW-1:0] waddr, raddr;
    logic [PER_W-1:0] p_wdata, p_rdata;
    logic [TW-1:0] d_wdata, d_rdata;

    ttm_ram #(.WIDTH(PER_W), .DEPTH(NUM_SLOTS)) u_per (
        .clk(clk), .we(p_we), .waddr(waddr), .wdata(p_wdata),
        .raddr(raddr), .rdata(p_rdata));
    ttm_ram #(.WIDTH(TW), .DEPTH(NUM_SLOTS)) u_dl (
        .clk(clk), .we(d_we), .waddr(waddr), .wdata(d_wdata),
        .raddr(raddr), .rdata(d_rdata));

    // Slot numbers used during a scan; the read address runs one slot ahead. Setup reads
    // the addressed slot, the cycle before a write-back reads the fired slot, and
    // every other state presents slot 0 so that a scan can start next cycle.
    logic [IW-1:0] cur_idx;
    assign cur_idx = cnt_reg[IW-1:0];
    assign raddr = (state_reg == S_SETUP) ? target_reg :
                   (state_reg == S_SCAN && cnt_reg < CW'(NUM_SLOTS - 1)) ?
                   IW'(cnt_reg + 1'b1) :
                   (state_reg == S_NEXT && cmd_reg == CMD_EXPIRE && o_fired) ?
                   best_reg : '0;

    // Target slot decode and lowest free slot.
    logic in_rng;
    logic tgt_act;
    logic [IW-1:0] free_idx;
    logic free_ok;
    assign in_rng = {{(32-SID_W){1'b0}}, sid_reg} < 32'(NUM_SLOTS);
    assign tgt_act = in_rng && act_reg[target_reg];
    always_comb
    begin
        free_idx = '0;
        free_ok = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                free_idx = IW'(i);
                free_ok = 1'b1;
            end
        end
    end

    // Deadline as seen after the pending update, for the front test.
    logic [TW-1:0] scan_dl;
    assign scan_dl = (cur_idx == target_reg && (cmd_reg == CMD_ADD ||
                      cmd_reg == CMD_RESET)) ? tdl_reg : d_rdata;

    // Per-slot candidate during scan: the shared compare unit.
    logic cand;
    logic better;
    always_comb
    begin
        cand = act_reg[cur_idx];
        if (cmd_reg == CMD_EXPIRE)
        begin
            cand = due_reg[cur_idx];
        end
        better = cand && (!best_ok_reg || scan_dl < best_dl_reg);
    end

    logic any_due;
    assign any_due = |due_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign ok = o_ok;
    assign timer_id = o_id;
    assign wait_ms = o_wait;
    assign is_earliest = o_front;
    assign fired = o_fired;
    assign last = o_last;
    // One-shot timers still waiting in the due set are already counted as freed.
    assign any_active = |(act_reg & (rec_reg | ~due_reg));

    // Write port control.
    always_comb
    begin
        p_we = 1'b0;
        d_we = 1'b0;
        waddr = target_reg;
        p_wdata = tper_reg;
        d_wdata = tdl_reg;
        if (state_reg == S_UPD)
        begin
            p_we = (cmd_reg == CMD_ADD || cmd_reg == CMD_RESET);
            d_we = (cmd_reg != CMD_CANCEL);
        end
        else if (state_reg == S_WB && rec_reg[target_reg])
        begin
            d_we = 1'b1;
            d_wdata = now_reg + TW'(p_rdata);
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg <= '0;
            rec_reg <= '0;
            due_reg <= '0;
            prev_reg <= '0;
            front_reg <= 1'b0;
            roll_reg <= ROLL_RESET;
            out_valid <= 1'b0;
            cnt_reg <= '0;
            cmd_reg <= '0;
            sid_reg <= '0;
            per_reg <= '0;
            recin_reg <= 1'b0;
            fnow_reg <= 1'b0;
            now_reg <= '0;
            target_reg <= '0;
            best_reg <= '0;
            best_ok_reg <= 1'b0;
            best_dl_reg <= '0;
            tdl_reg <= '0;
            tper_reg <= '0;
            roll_hit_reg <= 1'b0;
            o_ok <= 1'b0;
            o_id <= '0;
            o_wait <= '0;
            o_front <= 1'b0;
            o_fired <= 1'b0;
            o_last <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                roll_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= cmd;
                        sid_reg <= slot_id;
                        per_reg <= period_ms;
                        recin_reg <= recurring;
                        fnow_reg <= restart_now;
                        now_reg <= TW'(now_ms);
                        target_reg <= IW'(slot_id);
                        o_ok <= 1'b0; o_id <= '0; o_wait <= '0;
                        o_front <= 1'b0; o_fired <= 1'b0; o_last <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    // The addressed slot is read here and shows up in the next cycle.
                    cnt_reg <= '0;
                    best_ok_reg <= 1'b0;
                    due_reg <= '0;
                    roll_hit_reg <= now_reg < prev_reg &&
                                    (prev_reg - now_reg) > TW'(roll_reg);
                    if (cmd_reg == CMD_ADD)
                    begin
                        target_reg <= free_idx;
                        tper_reg <= per_reg;
                        tdl_reg <= now_reg + TW'(per_reg);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Target entry data now present on p_rdata/d_rdata.
                    unique case (cmd_reg)
                        CMD_ADD:
                        begin
                            o_ok <= free_ok;
                            o_id <= free_ok ? SID_W'(target_reg) : '0;
                            state_reg <= free_ok ? S_UPD : S_OUT;
                        end
                        CMD_CANCEL, CMD_REFRESH:
                        begin
                            o_id <= sid_reg;
                            o_ok <= tgt_act;
                            tdl_reg <= now_reg + TW'(p_rdata);
                            state_reg <= tgt_act ? S_UPD : S_OUT;
                        end
                        CMD_RESET:
                        begin
                            o_id <= sid_reg;
                            tper_reg <= per_reg;
                            tdl_reg <= (fnow_reg ? now_reg : d_rdata - TW'(p_rdata))
                                       + TW'(per_reg);
                            priority if (!in_rng)
                            begin
                                state_reg <= S_OUT;
                            end
                            else if (per_reg == p_rdata && !fnow_reg)
                            begin
                                o_ok <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else if (!act_reg[target_reg])
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                o_ok <= 1'b1;
                                state_reg <= S_UPD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            o_ok <= 1'b1;
                            front_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                        CMD_EXPIRE:
                        begin
                            o_ok <= 1'b1;
                            if (act_reg == '0)
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                prev_reg <= now_reg;
                                state_reg <= S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_UPD:
                begin
                    // Commit a table change; an add or reset then scans for the front test.
                    unique case (cmd_reg)
                        CMD_ADD:
                        begin
                            act_reg[target_reg] <= 1'b1;
                            rec_reg[target_reg] <= recin_reg;
                            state_reg <= S_SCAN;
                        end
                        CMD_CANCEL:
                        begin
                            act_reg[target_reg] <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        CMD_RESET:
                        begin
                            state_reg <= S_SCAN;
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // One slot per cycle through the deadline compare.
                    if (cmd_reg == CMD_EXPIRE && !o_fired)
                    begin
                        // First pass marks due slots.
                        if (act_reg[cur_idx] && (roll_hit_reg || d_rdata <= now_reg))
                        begin
                            due_reg[cur_idx] <= 1'b1;
                        end
                    end
                    else if (better)
                    begin
                        best_ok_reg <= 1'b1;
                        best_dl_reg <= scan_dl;
                        best_reg <= cur_idx;
                    end
                    if (cnt_reg == CW'(NUM_SLOTS - 1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_NEXT:
                begin
                    unique case (cmd_reg)
                        CMD_QUERY:
                        begin
                            o_wait <= !best_ok_reg ? OUT_TIME_W'(TMAX) :
                                      (now_reg >= best_dl_reg) ? '0 :
                                      OUT_TIME_W'(best_dl_reg - now_reg);
                            state_reg <= S_OUT;
                        end
                        CMD_EXPIRE:
                        begin
                            if (!o_fired)
                            begin
                                // Due set known; start ordered passes if any.
                                o_fired <= any_due;
                                best_ok_reg <= 1'b0;
                                state_reg <= any_due ? S_SCAN : S_OUT;
                            end
                            else
                            begin
                                target_reg <= best_reg;
                                o_id <= SID_W'(best_reg);
                                state_reg <= S_WB;
                            end
                        end
                        default:
                        begin
                            if (best_ok_reg && best_reg == target_reg && !front_reg)
                            begin
                                o_front <= 1'b1;
                                front_reg <= 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_WB:
                begin
                    // Period of the fired slot is on the read port here.
                    if (!rec_reg[target_reg])
                    begin
                        act_reg[target_reg] <= 1'b0;
                    end
                    due_reg[target_reg] <= 1'b0;
                    o_last <= (due_reg & ~(NUM_SLOTS'(1) << target_reg)) == '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                    end
                    else if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (o_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            best_ok_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule : timer_table_manager
`default_nettype wire

// ===== design/ttm_checker.sv =====
// ---------------------------------------------------------------------------
// Timer table manager checker
// Port-level properties of the command and result channels.
// ---------------------------------------------------------------------------
`default_nettype none
module ttm_checker
    import ttm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic ok,
    input wire logic fired,
    input wire logic is_earliest,
    input wire logic last
);
    // No new command while a result is pending.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("ready during result");
    // A command transfer makes the block busy on the next cycle.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accepted twice");
    // A fired result always reports success.
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> ok) else $error("fired without ok");
    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(last))
        else $error("result dropped");
    // Front flag never together with an expiry.
    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(fired && is_earliest)) else $error("front on expire");
endmodule : ttm_checker

bind timer_table_manager ttm_checker u_ttm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .ok(ok), .fired(fired),
    .is_earliest(is_earliest), .last(last));
`default_nettype wire

// ===== sim/tb_timer_table_manager.sv =====
// ---------------------------------------------------------------------------
// Timer table manager testbench
// Drives timer commands over the input channel and checks every result
// transfer against a cycle-free model of the slot table, with random idling
// on both sides, one long output stall and several rollover window settings.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_timer_table_manager;
    import ttm_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 2000000;

    // Result record as seen on the output channel.
    typedef struct packed {
        logic        ok;
        logic [3:0]  timer_id;
        logic [47:0] wait_ms;
        logic        is_earliest;
        logic        fired;
        logic        any_active;
        logic        last;
    } timer_result_t;

    // Command record as driven on the input channel.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  slot_id;
        logic [31:0] period_ms;
        logic        recurring;
        logic        restart_now;
        logic [47:0] now_ms;
    } timer_cmd_t;

    // Directed row: a command, and optionally a typed-in result.
    typedef struct packed {
        timer_cmd_t    c;
        logic          has_exp;
        timer_result_t r;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] cmd = '0;
    logic [3:0] slot_id = '0;
    logic [31:0] period_ms = '0;
    logic recurring = 1'b0;
    logic restart_now = 1'b0;
    logic [47:0] now_ms = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic ok, is_earliest, fired, any_active, last;
    logic [3:0] timer_id;
    logic [47:0] wait_ms;

    timer_table_manager DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .slot_id(slot_id),
        .period_ms(period_ms), .recurring(recurring), .restart_now(restart_now),
        .now_ms(now_ms), .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
        .timer_id(timer_id), .wait_ms(wait_ms), .is_earliest(is_earliest),
        .fired(fired), .any_active(any_active), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow timer table.
    logic        tbl_active [NSLOT];
    logic        tbl_recur [NSLOT];
    logic [31:0] tbl_period [NSLOT];
    logic [47:0] tbl_deadline [NSLOT];
    logic        tbl_written [NSLOT];
    logic [47:0] last_expire_time;
    logic        front_flag;
    logic [31:0] window_ms;

    timer_result_t pending_results [$];
    int mismatches = 0;
    int cycles = 0;
    bit rx_idle_on = 1'b1;
    bit tx_idle_on = 1'b1;
    bit hold_rx = 1'b0;

    function automatic logic any_timer_on();
        for (int i = 0; i < NSLOT; i++)
            if (tbl_active[i]) return 1'b1;
        return 1'b0;
    endfunction

    // Earliest slot among those set in the mask; lower slot wins on ties.
    function automatic int earliest_slot(logic [NSLOT-1:0] mask);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (mask[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best]))
                best = i;
        return best;
    endfunction

    function automatic logic [NSLOT-1:0] active_slots();
        logic [NSLOT-1:0] m;
        for (int i = 0; i < NSLOT; i++) m[i] = tbl_active[i];
        return m;
    endfunction

    function automatic logic claim_front(int s);
        logic f;
        f = (earliest_slot(active_slots()) == s) && !front_flag;
        if (f) front_flag = 1'b1;
        return f;
    endfunction

    function automatic void push_result(logic k_ok, logic [3:0] id, logic [47:0] w,
                                        logic fr, logic fi, logic la);
        timer_result_t r;
        r = '{k_ok, id, w, fr, fi, any_timer_on(), la};
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Applies one command to the shadow table and queues its results.
    function automatic void predict_timer_cmd(timer_cmd_t c);
        int s, e, n;
        logic [NSLOT-1:0] due;
        int order [NSLOT];
        logic roll, f;
        logic [47:0] start;
        s = c.slot_id;
        case (c.cmd)
            CMD_ADD:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (!tbl_active[i])
                    begin
                        tbl_active[i] = 1'b1;
                        tbl_recur[i] = c.recurring;
                        tbl_period[i] = c.period_ms;
                        tbl_written[i] = 1'b1;
                        tbl_deadline[i] = c.now_ms + 48'(c.period_ms);
                        f = claim_front(i);
                        push_result(1'b1, 4'(i), '0, f, 1'b0, 1'b1);
                        return;
                    end
                push_result(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
            end
            CMD_CANCEL:
            begin
                f = tbl_active[s];
                tbl_active[s] = 1'b0;
                push_result(f, c.slot_id, '0, 1'b0, 1'b0, 1'b1);
            end
            CMD_REFRESH:
            begin
                f = tbl_active[s];
                if (f) tbl_deadline[s] = c.now_ms + 48'(tbl_period[s]);
                push_result(f, c.slot_id, '0, 1'b0, 1'b0, 1'b1);
            end
            CMD_RESET:
            begin
                if (c.period_ms == tbl_period[s] && !c.restart_now)
                    push_result(1'b1, c.slot_id, '0, 1'b0, 1'b0, 1'b1);
                else if (!tbl_active[s])
                    push_result(1'b0, c.slot_id, '0, 1'b0, 1'b0, 1'b1);
                else
                begin
                    start = c.restart_now ? c.now_ms
                                          : tbl_deadline[s] - 48'(tbl_period[s]);
                    tbl_period[s] = c.period_ms;
                    tbl_deadline[s] = start + 48'(c.period_ms);
                    f = claim_front(s);
                    push_result(1'b1, c.slot_id, '0, f, 1'b0, 1'b1);
                end
            end
            CMD_QUERY:
            begin
                e = earliest_slot(active_slots());
                front_flag = 1'b0;
                if (e < 0) push_result(1'b1, '0, ALL_ONES, 1'b0, 1'b0, 1'b1);
                else if (c.now_ms >= tbl_deadline[e])
                    push_result(1'b1, '0, '0, 1'b0, 1'b0, 1'b1);
                else
                    push_result(1'b1, '0, tbl_deadline[e] - c.now_ms, 1'b0, 1'b0, 1'b1);
            end
            CMD_EXPIRE:
            begin
                if (!any_timer_on())
                begin
                    push_result(1'b1, '0, '0, 1'b0, 1'b0, 1'b1);
                    return;
                end
                roll = c.now_ms < last_expire_time &&
                       (last_expire_time - c.now_ms) > 48'(window_ms);
                last_expire_time = c.now_ms;
                due = '0;
                for (int i = 0; i < NSLOT; i++)
                    due[i] = tbl_active[i] && (roll || tbl_deadline[i] <= c.now_ms);
                n = 0;
                while (due != '0)
                begin
                    e = earliest_slot(due);
                    order[n] = e;
                    n++;
                    due[e] = 1'b0;
                end
                if (n == 0)
                begin
                    push_result(1'b1, '0, '0, 1'b0, 1'b0, 1'b1);
                    return;
                end
                for (int k = 0; k < n; k++)
                    if (tbl_recur[order[k]])
                        tbl_deadline[order[k]] = c.now_ms + 48'(tbl_period[order[k]]);
                    else
                        tbl_active[order[k]] = 1'b0;
                for (int k = 0; k < n; k++)
                    push_result(1'b1, 4'(order[k]), '0, 1'b0, 1'b1, k == n - 1);
            end
            default:
                push_result(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
        endcase
    endfunction

    // Sends one command and waits for its transfer. Valid stays high after the
    // transfer unless the sender idles or the caller drops it.
    task automatic send_cmd(timer_cmd_t c);
        while (tx_idle_on && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {cmd, slot_id, period_ms, recurring, restart_now, now_ms} <= c;
        predict_timer_cmd(c);
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_and_write_window(logic [31:0] w);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_ms = w;
    endtask

    // A reset of a never-written slot whose shortcut test would read its period
    // is never sent; such rows are turned into cancels.
    function automatic timer_cmd_t legalize(timer_cmd_t c);
        if (c.cmd == CMD_RESET && !tbl_written[c.slot_id]) c.cmd = CMD_CANCEL;
        return c;
    endfunction

    // Random command, mostly adds and expires with clustered times.
    logic [47:0] sim_now;
    function automatic timer_cmd_t random_cmd();
        timer_cmd_t c;
        int p;
        c.slot_id = 4'($urandom_range(15));
        c.recurring = 1'($urandom);
        c.restart_now = 1'($urandom);
        p = $urandom_range(99);
        c.period_ms = (p < 10) ? $urandom : 32'($urandom_range(300));
        p = $urandom_range(99);
        if (p < 5) sim_now = 48'({$urandom, $urandom});
        else if (p < 10) sim_now = sim_now - 48'($urandom_range(5000000));
        else sim_now = sim_now + 48'($urandom_range(120));
        c.now_ms = sim_now;
        p = $urandom_range(99);
        if (p < 30) c.cmd = CMD_ADD;
        else if (p < 40) c.cmd = CMD_CANCEL;
        else if (p < 50) c.cmd = CMD_REFRESH;
        else if (p < 62) c.cmd = CMD_RESET;
        else if (p < 72) c.cmd = CMD_QUERY;
        else if (p < 97) c.cmd = CMD_EXPIRE;
        else c.cmd = 3'($urandom_range(6, 7));
        if (c.cmd == CMD_RESET && $urandom_range(3) == 0 && tbl_written[c.slot_id])
            c.period_ms = tbl_period[c.slot_id];
        return legalize(c);
    endfunction

    // Output side: random stalls, checking of every result transfer.
    always @(posedge clk)
    begin
        timer_result_t got, want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{ok, timer_id, wait_ms, is_earliest, fired, any_active, last};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            out_ready <= !hold_rx && !(rx_idle_on && $urandom_range(99) < 32);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    directed_row_t rows [$];

    function automatic void add_row(logic [2:0] k, logic [3:0] s, logic [31:0] p,
                                    logic rc, logic fn, logic [47:0] t,
                                    logic he, timer_result_t r);
        directed_row_t d;
        d.c = '{k, s, p, rc, fn, t};
        d.has_exp = he;
        d.r = r;
        rows.insert(rows.size(), d);
    endfunction

    initial
    begin
        timer_cmd_t c;
        int wait_cycles;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_active[i] = 1'b0;
            tbl_recur[i] = 1'b0;
            tbl_period[i] = '0;
            tbl_deadline[i] = '0;
            tbl_written[i] = 1'b0;
        end
        last_expire_time = '0;
        front_flag = 1'b0;
        window_ms = ROLL_RESET;
        sim_now = 48'd1000;

        // Directed table: empty-table cases first, then extremes.
        add_row(CMD_QUERY, 0, 0, 0, 0, 48'd5, 1, '{1, 0, ALL_ONES, 0, 0, 0, 1});
        add_row(CMD_EXPIRE, 0, 0, 0, 0, 48'd5, 1, '{1, 0, 0, 0, 0, 0, 1});
        add_row(CMD_CANCEL, 4'd15, 0, 0, 0, 48'd5, 1, '{0, 15, 0, 0, 0, 0, 1});
        add_row(CMD_REFRESH, 4'd3, 0, 0, 0, 48'd5, 1, '{0, 3, 0, 0, 0, 0, 1});
        add_row(3'd6, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 1});
        add_row(3'd7, 4'd15, 32'hFFFF_FFFF, 1, 1, ALL_ONES, 1, '{0, 0, 0, 0, 0, 0, 1});
        add_row(CMD_ADD, 0, 32'd100, 0, 0, 48'd0, 1, '{1, 0, 0, 1, 0, 1, 1});
        add_row(CMD_ADD, 0, 32'hFFFF_FFFF, 1, 0, ALL_ONES, 0, '0);
        add_row(CMD_ADD, 0, 32'd0, 1, 0, 48'd50, 0, '0);
        add_row(CMD_QUERY, 0, 0, 0, 0, 48'd10, 0, '0);
        add_row(CMD_RESET, 4'd2, 32'd0, 0, 0, 48'd10, 0, '0);
        add_row(CMD_RESET, 4'd0, 32'd20, 0, 0, 48'd10, 0, '0);
        add_row(CMD_RESET, 4'd2, 32'd5, 1, 1, 48'd30, 0, '0);
        add_row(CMD_REFRESH, 4'd0, 0, 0, 0, 48'd40, 0, '0);
        add_row(CMD_QUERY, 0, 0, 0, 0, 48'd40, 0, '0);
        add_row(CMD_EXPIRE, 0, 0, 0, 0, 48'd100, 0, '0);
        add_row(CMD_EXPIRE, 0, 0, 0, 0, 48'd10, 0, '0);
        add_row(CMD_CANCEL, 4'd1, 0, 0, 0, 48'd10, 0, '0);
        add_row(CMD_CANCEL, 4'd2, 0, 0, 0, 48'd10, 0, '0);
        add_row(CMD_RESET, 4'd2, 32'd7, 0, 1, 48'd10, 0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            c = legalize(rows[i].c);
            send_cmd(c);
            if (rows[i].has_exp && pending_results[$] !== rows[i].r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: table %p model %p", i, rows[i].r,
                             pending_results[$]);
            end
        end

        // Fill the table while the receiver holds off, so the input stalls.
        hold_rx = 1'b1;
        fork
            begin
                for (int i = 0; i < 18; i++)
                begin
                    c = '{CMD_ADD, 0, 32'($urandom_range(50)), 1'($urandom), 0, sim_now};
                    send_cmd(c);
                end
                for (int i = 0; i < 3; i++) send_cmd(random_cmd());
            end
            begin
                wait_cycles = 0;
                while (wait_cycles < 300)
                begin
                    @(posedge clk);
                    wait_cycles++;
                end
                hold_rx = 1'b0;
            end
        join
        c = '{CMD_EXPIRE, 0, 0, 0, 0, sim_now + 48'd60};
        send_cmd(c);

        // Random phases across window settings, one stretch without idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: drain_and_write_window(32'd0);
                1: drain_and_write_window(32'hFFFF_FFFF);
                2: drain_and_write_window(32'd1000);
                default: drain_and_write_window(ROLL_RESET);
            endcase
            rx_idle_on = (ph != 2);
            tx_idle_on = (ph != 2);
            for (int i = 0; i < 100; i++) send_cmd(random_cmd());
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
